@@ rtl/core/idle_gap_burst_framer_assert.svh @@
// assertion macros for the idle gap burst framer
`ifndef IDLE_GAP_BURST_FRAMER_ASSERT_SVH
`define IDLE_GAP_BURST_FRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IGBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("igbf: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define IGBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("igbf: next-cycle check failed");

`endif

@@ rtl/core/igbf_pkg.sv @@
// shared types and constants of the idle gap burst framer
package igbf_pkg;

   localparam int MAX_CHARS  = 63;
   localparam int RAW_LIMIT  = 511;
   localparam int CHAR_CNT_W = $clog2(MAX_CHARS + 1);
   localparam int ADDR_W     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int RAW_CNT_W  = $clog2(RAW_LIMIT + 1);
   localparam int IDLE_W     = 16;
   localparam int CHAR_W     = 7;
   localparam int BYTE_W     = 8;

   localparam logic [BYTE_W-1:0] CHAR_LO = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_HI = 8'd126;
   localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd20;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_IDLE_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      ACT_BYTE   = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_ERROR  = 2'd2,
      ACT_BENIGN = 2'd3
   } action_type;

   typedef enum logic {
      ST_COLLECT = 1'b0,
      ST_DRAIN   = 1'b1
   } state_type;

   typedef struct packed {
      action_type        action;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
   } rsp_type;

   typedef struct packed {
      logic [IDLE_W-1:0] idle_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic draining;
      logic rd_pending;
   } status_type;

endpackage

@@ rtl/core/igbf_ram.sv @@
// generic single-write, single-read ram with registered read data
module igbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/igbf_csr.sv @@
// configuration register block with apb-style access
module igbf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [igbf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [igbf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic                             csr_pready,
   output logic [igbf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output igbf_pkg::cfg_type                cfg
);

   logic [igbf_pkg::IDLE_W-1:0] timeout_ff;
   logic [igbf_pkg::IDLE_W-1:0] timeout_in;
   logic                        hit;

   assign hit = (csr_paddr[igbf_pkg::CSR_ADDR_W-1:2] == igbf_pkg::CSR_IDX_IDLE_TIMEOUT);

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         timeout_in = csr_pwdata[igbf_pkg::IDLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= igbf_pkg::IDLE_TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? igbf_pkg::CSR_DATA_W'(timeout_ff) : '0;
   assign cfg.idle_timeout_ticks = timeout_ff;

endmodule

@@ rtl/core/igbf_engine.sv @@
// burst counters, drain sequencer and result register
module igbf_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  igbf_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  igbf_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output igbf_pkg::rsp_type               rsp_payload,
   output logic                            ram_wr_en,
   output logic [igbf_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [igbf_pkg::CHAR_W-1:0]     ram_wr_data,
   output logic                            ram_rd_en,
   output logic [igbf_pkg::ADDR_W-1:0]     ram_rd_addr,
   input  logic [igbf_pkg::CHAR_W-1:0]     ram_rd_data,
   output igbf_pkg::status_type            status
);

   igbf_pkg::state_type state_ff, state_in;

   logic [igbf_pkg::CHAR_CNT_W-1:0] char_count_ff, char_count_in;
   logic [igbf_pkg::RAW_CNT_W-1:0]  raw_count_ff, raw_count_in;
   logic [igbf_pkg::IDLE_W-1:0]     idle_count_ff, idle_count_in;
   logic [igbf_pkg::CHAR_CNT_W-1:0] total_ff, total_in;
   logic [igbf_pkg::CHAR_CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                            pend_ff, pend_in;
   logic                            pend_last_ff, pend_last_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   igbf_pkg::rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                            accept;
   logic                            printable;
   logic                            load;
   logic                            issue;
   logic [igbf_pkg::IDLE_W-1:0]     idle_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= igbf_pkg::ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         raw_count_ff  <= '0;
         idle_count_ff <= '0;
         rd_idx_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         raw_count_ff  <= raw_count_in;
         idle_count_ff <= idle_count_in;
         rd_idx_ff     <= rd_idx_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff       <= total_in;
      pend_last_ff   <= pend_last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign printable = (req_payload.rx_byte >= igbf_pkg::CHAR_LO) &&
                      (req_payload.rx_byte <= igbf_pkg::CHAR_HI);
   assign idle_inc  = (idle_count_ff == '1) ? idle_count_ff : idle_count_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      char_count_in  = char_count_ff;
      raw_count_in   = raw_count_ff;
      idle_count_in  = idle_count_ff;
      total_in       = total_ff;
      rd_idx_in      = rd_idx_ff;
      pend_last_in   = pend_last_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      ram_wr_en      = 1'b0;

      accept = req_valid && (state_ff == igbf_pkg::ST_COLLECT);
      load   = pend_ff && (!rsp_valid_ff || !rsp_stall);
      issue  = (state_ff == igbf_pkg::ST_DRAIN) && (rd_idx_ff != total_ff) &&
               (!pend_ff || load);
      pend_in = issue || (pend_ff && !load);

      if (accept) begin
         unique case (req_payload.action)
            igbf_pkg::ACT_BYTE: begin
               idle_count_in = '0;
               if (raw_count_ff < igbf_pkg::RAW_CNT_W'(igbf_pkg::RAW_LIMIT)) begin
                  raw_count_in = raw_count_ff + 1'b1;
                  if (printable &&
                      char_count_ff < igbf_pkg::CHAR_CNT_W'(igbf_pkg::MAX_CHARS)) begin
                     ram_wr_en     = 1'b1;
                     char_count_in = char_count_ff + 1'b1;
                  end
               end
            end
            igbf_pkg::ACT_TICK: begin
               if (raw_count_ff != '0) begin
                  idle_count_in = idle_inc;
                  if (idle_inc >= cfg.idle_timeout_ticks) begin
                     char_count_in = '0;
                     raw_count_in  = '0;
                     idle_count_in = '0;
                     if (char_count_ff != '0) begin
                        total_in  = char_count_ff;
                        rd_idx_in = '0;
                        state_in  = igbf_pkg::ST_DRAIN;
                     end
                  end
               end
            end
            igbf_pkg::ACT_ERROR: begin
               char_count_in = '0;
               raw_count_in  = '0;
               idle_count_in = '0;
            end
            igbf_pkg::ACT_BENIGN: begin
               idle_count_in = '0;
            end
            default: begin
               idle_count_in = idle_count_ff;
            end
         endcase
      end

      if (issue) begin
         rd_idx_in    = rd_idx_ff + 1'b1;
         pend_last_in = ((rd_idx_ff + 1'b1) == total_ff);
      end

      if ((state_ff == igbf_pkg::ST_DRAIN) && (rd_idx_ff == total_ff) && !pend_in) begin
         state_in = igbf_pkg::ST_COLLECT;
      end

      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_char = ram_rd_data;
         rsp_payload_in.out_last = pend_last_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall   = (state_ff == igbf_pkg::ST_DRAIN);
   assign ram_wr_addr = char_count_ff[igbf_pkg::ADDR_W-1:0];
   assign ram_wr_data = req_payload.rx_byte[igbf_pkg::CHAR_W-1:0];
   assign ram_rd_en   = issue;
   assign ram_rd_addr = rd_idx_ff[igbf_pkg::ADDR_W-1:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign status.draining   = (state_ff == igbf_pkg::ST_DRAIN);
   assign status.rd_pending = pend_ff;

endmodule

@@ rtl/core/idle_gap_burst_framer.sv @@
// top level of the idle gap burst framer
//
//   port group   direction   role
//   req_*        in          bytes, ticks and line events, one item each
//   rsp_*        out         characters of a finished burst, last mark on the final one
//   csr_*        in/out      idle timeout register, apb-style
//
// one input item per cycle while a burst is being collected
// a timeout that ends a burst with n kept characters stalls req while the n characters drain;
// the character store has one read port, so one character per cycle leaves it
// rsp stalls hold the drain; the result register lets req resume while the last
// character still waits
// reset clears the counters at once; the character store needs no clearing pass
module idle_gap_burst_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  igbf_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output igbf_pkg::rsp_type               rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [igbf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [igbf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic                            csr_pready,
   output logic [igbf_pkg::CSR_DATA_W-1:0] csr_prdata
);

`include "idle_gap_burst_framer_assert.svh"

   igbf_pkg::cfg_type               cfg;
   igbf_pkg::status_type            status;
   logic                            ram_wr_en;
   logic [igbf_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic [igbf_pkg::CHAR_W-1:0]     ram_wr_data;
   logic                            ram_rd_en;
   logic [igbf_pkg::ADDR_W-1:0]     ram_rd_addr;
   logic [igbf_pkg::CHAR_W-1:0]     ram_rd_data;
   logic                            rsp_char_ok;

   igbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   igbf_ram #(
      .WIDTH (igbf_pkg::CHAR_W),
      .DEPTH (igbf_pkg::MAX_CHARS)
   ) u_char_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   igbf_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .status      (status)
   );

   assign rsp_char_ok = ({1'b0, rsp_payload.out_char} >= igbf_pkg::CHAR_LO) &&
                        ({1'b0, rsp_payload.out_char} <= igbf_pkg::CHAR_HI);

   `IGBF_ASSERT_NOW(a_stall_while_drain, clock, reset, status.draining, req_stall)
   `IGBF_ASSERT_NOW(a_no_write_on_read, clock, reset, ram_rd_en, !ram_wr_en)
   `IGBF_ASSERT_NEXT(a_read_pending, clock, reset, ram_rd_en, status.rd_pending)
   `IGBF_ASSERT_NOW(a_char_printable, clock, reset, rsp_valid, rsp_char_ok)

endmodule
